// ===== design/lsac_pkg.sv =====
// Package for the LRU set-associative cache model.
// Holds sizes, line and row types, register indexes and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
package lsac_pkg;
    localparam int MAX_INDEX_BITS = 10;
    localparam int WAYS           = 8;
    localparam int ADDR_WIDTH     = 64;
    localparam int COUNT_WIDTH    = 32;
    localparam int NUM_SETS       = 1 << MAX_INDEX_BITS;
    localparam int SET_W          = MAX_INDEX_BITS;
    localparam int AGE_W          = 3;
    localparam int NW_W           = 4;
    localparam int SPLIT_W        = 7;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] tag;
        logic                  valid;
        logic                  dirty;
        logic [AGE_W-1:0]      age;
    } line_t;

    typedef line_t [WAYS-1:0] row_t;

    typedef struct packed {
        logic             capture;
        logic             update;
        logic             clear_wr;
        logic [SET_W-1:0] clear_idx;
    } lsac_cmd_t;

    typedef struct packed {
        logic out_busy;
    } lsac_stat_t;
endpackage

// ===== design/lsac_ctrl.sv =====
// Controller state machine for the cache model: clearing sweep, accept, update.
// Depends on lsac_pkg.
`timescale 1ns / 1ps
module lsac_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lsac_pkg::lsac_stat_t stat,
    output lsac_pkg::lsac_cmd_t  cmd
);
    import lsac_pkg::*;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_UPDATE} state_t;

    state_t           state_reg;
    logic [SET_W-1:0] clr_idx_reg;
    logic             in_ready_reg;

    assign in_ready      = in_ready_reg;
    assign cmd.capture   = in_valid && in_ready_reg;
    assign cmd.update    = (state_reg == S_UPDATE) && !stat.out_busy;
    assign cmd.clear_wr  = (state_reg == S_CLEAR);
    assign cmd.clear_idx = clr_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_idx_reg  <= '0;
            in_ready_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == SET_W'(NUM_SETS - 1))
                    begin
                        state_reg    <= S_IDLE;
                        in_ready_reg <= 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid && in_ready_reg)
                    begin
                        state_reg    <= S_UPDATE;
                        in_ready_reg <= 1'b0;
                    end
                end
                S_UPDATE:
                begin
                    if (!stat.out_busy)
                    begin
                        state_reg    <= S_IDLE;
                        in_ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= S_CLEAR;
                    in_ready_reg <= 1'b0;
                end
            endcase
        end
    end
endmodule

// ===== design/lsac_dpath.sv =====
// Datapath for the cache model: config registers, set memory, lookup and LRU update,
// counters and the result register. Depends on lsac_pkg.
`timescale 1ns / 1ps
module lsac_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lsac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lsac_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                operation,
    input  logic [lsac_pkg::ADDR_WIDTH-1:0]     address,
    input  lsac_pkg::lsac_cmd_t                 cmd,
    output lsac_pkg::lsac_stat_t                stat,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic                                evicted,
    output logic                                evicted_dirty,
    output logic [lsac_pkg::COUNT_WIDTH-1:0]    hit_count,
    output logic [lsac_pkg::COUNT_WIDTH-1:0]    miss_count,
    output logic [lsac_pkg::COUNT_WIDTH-1:0]    eviction_count,
    output logic [lsac_pkg::COUNT_WIDTH-1:0]    dirty_count,
    output logic [lsac_pkg::COUNT_WIDTH-1:0]    dirty_eviction_count
);
    import lsac_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [3:0] index_bits_reg;
    logic [5:0] offset_bits_reg;
    logic [3:0] ways_in_use_reg;

    row_t mem [NUM_SETS];
    row_t rd_row_reg;

    logic                  store_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;
    logic [SET_W-1:0]      set_reg;
    logic [NW_W-1:0]       nw_reg;

    logic out_valid_reg, hit_reg, evicted_reg, ev_dirty_reg;
    logic [COUNT_WIDTH-1:0] hits_reg, misses_reg, evs_reg, held_reg, dev_reg;

    // Address split for the incoming beat.
    logic [3:0]            ib;
    logic [NW_W-1:0]       nw;
    logic [SPLIT_W-1:0]    split;
    logic [ADDR_WIDTH-1:0] tag_c, shifted;
    logic [SET_W-1:0]      set_c, idx_mask;

    always_comb
    begin
        ib       = (index_bits_reg > 4'(MAX_INDEX_BITS)) ? 4'(MAX_INDEX_BITS) : index_bits_reg;
        nw       = (ways_in_use_reg == '0) ? NW_W'(1)
                 : ((ways_in_use_reg > NW_W'(WAYS)) ? NW_W'(WAYS) : ways_in_use_reg);
        split    = SPLIT_W'(offset_bits_reg) + SPLIT_W'(ib);
        tag_c    = (split >= SPLIT_W'(ADDR_WIDTH)) ? '0 : (address & ({ADDR_WIDTH{1'b1}} << split));
        shifted  = address >> offset_bits_reg;
        idx_mask = ~({SET_W{1'b1}} << ib);
        set_c    = shifted[SET_W-1:0] & idx_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg  <= '0;
            offset_bits_reg <= '0;
            ways_in_use_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INDEX_BITS:  index_bits_reg  <= cfg_data[3:0];
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            store_reg  <= operation;
            tag_reg    <= tag_c;
            set_reg    <= set_c;
            nw_reg     <= nw;
            rd_row_reg <= mem[set_c];
        end
    end

    // Lookup and LRU update on the row read for the current beat.
    logic                 found, has_free;
    logic [NW_W-1:0]      fw, frw, vw, nwy;
    logic [AGE_W-1:0]     best, ha;
    logic                 in_use;
    logic                 do_evict, ev_dirty;
    row_t                 new_row;

    always_comb
    begin
        found    = 1'b0;
        has_free = 1'b0;
        fw       = '0;
        frw      = '0;
        vw       = '0;
        best     = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            in_use = NW_W'(w) < nw_reg;
            if (in_use && rd_row_reg[w].valid)
            begin
                if (!found && rd_row_reg[w].tag == tag_reg)
                begin
                    found = 1'b1;
                    fw    = NW_W'(w);
                end
            end
            else if (in_use && !has_free)
            begin
                has_free = 1'b1;
                frw      = NW_W'(w);
            end
            if (in_use && (w == 0 || rd_row_reg[w].age > best))
            begin
                best = rd_row_reg[w].age;
                vw   = NW_W'(w);
            end
        end
        ha       = rd_row_reg[fw[$clog2(WAYS)-1:0]].age;
        do_evict = !found && !has_free;
        nwy      = has_free ? frw : vw;
        ev_dirty = do_evict && rd_row_reg[vw[$clog2(WAYS)-1:0]].dirty;
        new_row  = rd_row_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            in_use = NW_W'(w) < nw_reg;
            if (found)
            begin
                if (NW_W'(w) == fw)
                begin
                    new_row[w].age = '0;
                    if (store_reg)
                        new_row[w].dirty = 1'b1;
                end
                else if (in_use && rd_row_reg[w].valid && rd_row_reg[w].age < ha)
                    new_row[w].age = rd_row_reg[w].age + 1'b1;
            end
            else
            begin
                if (NW_W'(w) == nwy)
                begin
                    new_row[w].tag   = tag_reg;
                    new_row[w].valid = 1'b1;
                    new_row[w].dirty = store_reg;
                    new_row[w].age   = '0;
                end
                else if (in_use && rd_row_reg[w].valid && rd_row_reg[w].age < AGE_MAX)
                    new_row[w].age = rd_row_reg[w].age + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
            mem[cmd.clear_idx] <= '0;
        else if (cmd.update)
            mem[set_reg] <= new_row;
    end

    // Dirty-line count: a dirty eviction lowers it before a store fill raises it.
    logic [COUNT_WIDTH-1:0] held_dec;
    logic                   fresh_dirty;

    always_comb
    begin
        held_dec    = (ev_dirty && held_reg != '0) ? held_reg - 1'b1 : held_reg;
        fresh_dirty = store_reg && (!found || !rd_row_reg[fw[$clog2(WAYS)-1:0]].dirty);
    end

    assign stat.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            evs_reg       <= '0;
            held_reg      <= '0;
            dev_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.update)
            begin
                out_valid_reg <= 1'b1;
                if (found && hits_reg != CNT_MAX)
                    hits_reg <= hits_reg + 1'b1;
                if (!found && misses_reg != CNT_MAX)
                    misses_reg <= misses_reg + 1'b1;
                if (do_evict && evs_reg != CNT_MAX)
                    evs_reg <= evs_reg + 1'b1;
                if (ev_dirty && dev_reg != CNT_MAX)
                    dev_reg <= dev_reg + 1'b1;
                held_reg <= (fresh_dirty && held_dec != CNT_MAX) ? held_dec + 1'b1 : held_dec;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            hit_reg      <= found;
            evicted_reg  <= do_evict;
            ev_dirty_reg <= ev_dirty;
        end
    end

    assign out_valid            = out_valid_reg;
    assign hit                  = hit_reg;
    assign evicted              = evicted_reg;
    assign evicted_dirty        = ev_dirty_reg;
    assign hit_count            = hits_reg;
    assign miss_count           = misses_reg;
    assign eviction_count       = evs_reg;
    assign dirty_count          = held_reg;
    assign dirty_eviction_count = dev_reg;
endmodule

// ===== design/lru_set_assoc_cache_sim_top.sv =====
// Top level of the LRU set-associative write-back cache model.
// Joins lsac_ctrl and lsac_dpath; depends on lsac_pkg.
//
//   Channel  Handshake              Payload
//   -------  ---------------------  -------------------------------------------------
//   in       in_valid / in_ready    operation, address
//   out      out_valid / out_ready  hit, evicted, evicted_dirty, five running counts
//   cfg      cfg_we                 cfg_index, cfg_data (write only)
//
// For an access, the beat is accepted and its set row is read from the set memory,
// then the row is compared, updated and written back while the result is loaded
// into the output register. After reset a clearing pass zeroes all 1024 sets of
// the set memory, one set per cycle; in_ready stays low meanwhile. A stalled
// output holds the update step until its beat is taken, so the next input can be
// accepted while a result waits.
`timescale 1ns / 1ps
module lru_set_assoc_cache_sim_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lsac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lsac_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             operation,
    input  logic [lsac_pkg::ADDR_WIDTH-1:0]  address,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             hit,
    output logic                             evicted,
    output logic                             evicted_dirty,
    output logic [lsac_pkg::COUNT_WIDTH-1:0] hit_count,
    output logic [lsac_pkg::COUNT_WIDTH-1:0] miss_count,
    output logic [lsac_pkg::COUNT_WIDTH-1:0] eviction_count,
    output logic [lsac_pkg::COUNT_WIDTH-1:0] dirty_count,
    output logic [lsac_pkg::COUNT_WIDTH-1:0] dirty_eviction_count
);
    import lsac_pkg::*;

    // The controller steps the clearing sweep and sequences each access.
    lsac_cmd_t  cmd;
    lsac_stat_t stat;

    lsac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath owns the set memory, the counters and the result register.
    lsac_dpath u_dpath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .operation            (operation),
        .address              (address),
        .cmd                  (cmd),
        .stat                 (stat),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .hit                  (hit),
        .evicted              (evicted),
        .evicted_dirty        (evicted_dirty),
        .hit_count            (hit_count),
        .miss_count           (miss_count),
        .eviction_count       (eviction_count),
        .dirty_count          (dirty_count),
        .dirty_eviction_count (dirty_eviction_count)
    );
endmodule

// ===== tb/lru_set_assoc_cache_sim_top_tb.sv =====
// Self-checking testbench for the LRU set-associative write-back cache model.
// Drives accesses and register writes, predicts every result, compares each beat.
// Depends on lsac_pkg and lru_set_assoc_cache_sim_top.
`timescale 1ns / 1ps
module lru_set_assoc_cache_sim_top_tb;
    import lsac_pkg::*;

    typedef struct {
        logic        hit;
        logic        evicted;
        logic        evicted_dirty;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
        logic [31:0] eviction_count;
        logic [31:0] dirty_count;
        logic [31:0] dirty_eviction_count;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic operation;
    logic [ADDR_WIDTH-1:0] address;
    logic out_valid;
    logic out_ready;
    logic hit;
    logic evicted;
    logic evicted_dirty;
    logic [COUNT_WIDTH-1:0] hit_count;
    logic [COUNT_WIDTH-1:0] miss_count;
    logic [COUNT_WIDTH-1:0] eviction_count;
    logic [COUNT_WIDTH-1:0] dirty_count;
    logic [COUNT_WIDTH-1:0] dirty_eviction_count;

    // Predictor state: a mirror of the tag store, the registers and the counters.
    logic [63:0] mir_tag [NUM_SETS*WAYS];
    logic        mir_valid [NUM_SETS*WAYS];
    logic        mir_dirty [NUM_SETS*WAYS];
    logic [2:0]  mir_age [NUM_SETS*WAYS];
    logic [3:0]  reg_index_bits;
    logic [5:0]  reg_offset_bits;
    logic [3:0]  reg_ways;
    logic [31:0] n_hits, n_misses, n_evictions, n_dirty, n_dirty_evictions;

    outcome_t expected_outcomes[$];
    int  failures;
    int  send_idle_pct;
    int  recv_stall_pct;

    lru_set_assoc_cache_sim_top dut (.*);

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [31:0] sat_inc(logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    function automatic logic [2:0] age_inc(logic [2:0] a);
        return (a == AGE_MAX) ? a : a + 3'd1;
    endfunction

    // Looks the access up in the mirrored store, updates it, and returns the outcome.
    function automatic outcome_t predict_access(logic store, logic [63:0] addr);
        outcome_t r;
        int ib, nw, split, base, found, free_way, victim, hi, ni;
        logic [63:0] tag_v;
        logic [63:0] set_v;
        logic [2:0] a, best;
        ib = (reg_index_bits > MAX_INDEX_BITS) ? MAX_INDEX_BITS : reg_index_bits;
        nw = (reg_ways == 0) ? 1 : ((reg_ways > WAYS) ? WAYS : reg_ways);
        split = reg_offset_bits + ib;
        tag_v = (split < 64) ? (addr & ~((64'd1 << split) - 64'd1)) : 64'd0;
        set_v = (addr >> reg_offset_bits) & ((64'd1 << ib) - 64'd1);
        base = int'(set_v) * WAYS;
        found = -1;
        free_way = -1;
        r.hit = 1'b0;
        r.evicted = 1'b0;
        r.evicted_dirty = 1'b0;
        for (int w = 0; w < nw; w++)
        begin
            if (mir_valid[base+w])
            begin
                if (found < 0 && mir_tag[base+w] == tag_v)
                    found = w;
            end
            else if (free_way < 0)
                free_way = w;
        end
        if (found >= 0)
        begin
            hi = base + found;
            a = mir_age[hi];
            r.hit = 1'b1;
            n_hits = sat_inc(n_hits);
            for (int w = 0; w < nw; w++)
                if (mir_valid[base+w] && base + w != hi && mir_age[base+w] < a)
                    mir_age[base+w] = age_inc(mir_age[base+w]);
            mir_age[hi] = 3'd0;
            if (store && !mir_dirty[hi])
            begin
                mir_dirty[hi] = 1'b1;
                n_dirty = sat_inc(n_dirty);
            end
        end
        else
        begin
            n_misses = sat_inc(n_misses);
            if (free_way < 0)
            begin
                victim = 0;
                best = 3'd0;
                for (int w = 0; w < nw; w++)
                    if (w == 0 || mir_age[base+w] > best)
                    begin
                        best = mir_age[base+w];
                        victim = w;
                    end
                ni = base + victim;
                r.evicted = 1'b1;
                n_evictions = sat_inc(n_evictions);
                if (mir_dirty[ni])
                begin
                    r.evicted_dirty = 1'b1;
                    n_dirty_evictions = sat_inc(n_dirty_evictions);
                    if (n_dirty != 0)
                        n_dirty = n_dirty - 32'd1;
                end
                mir_valid[ni] = 1'b0;
            end
            else
                ni = base + free_way;
            for (int w = 0; w < nw; w++)
                if (mir_valid[base+w])
                    mir_age[base+w] = age_inc(mir_age[base+w]);
            mir_valid[ni] = 1'b1;
            mir_tag[ni] = tag_v;
            mir_age[ni] = 3'd0;
            mir_dirty[ni] = store;
            if (store)
                n_dirty = sat_inc(n_dirty);
        end
        r.hit_count = n_hits;
        r.miss_count = n_misses;
        r.eviction_count = n_evictions;
        r.dirty_count = n_dirty;
        r.dirty_eviction_count = n_dirty_evictions;
        return r;
    endfunction

    // Sends one access beat, with a random idle gap first, and records the prediction.
    // in_valid is dropped only when the sender idles or waits for the results, so each edge sees one drive.
    task automatic send_access(logic store, logic [63:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= store;
        address <= addr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_outcomes.push_back(predict_access(store, addr));
    endtask

    // Drops in_valid, waits for all results, then lets the pipeline drain.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_INDEX_BITS:  reg_index_bits = val[3:0];
            CFG_OFFSET_BITS: reg_offset_bits = val;
            CFG_WAYS_IN_USE: reg_ways = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(int ib, int ob, int nw);
        wait_idle();
        write_reg(CFG_INDEX_BITS, CFG_DATA_W'(ib));
        write_reg(CFG_OFFSET_BITS, CFG_DATA_W'(ob));
        write_reg(CFG_WAYS_IN_USE, CFG_DATA_W'(nw));
        cfg_we <= 1'b0;
    endtask

    // Builds an address that lands in a small pool of tags so that hits and
    // evictions both happen often, with fully random addresses mixed in.
    function automatic logic [63:0] pick_address();
        logic [63:0] a;
        a = {$urandom, $urandom};
        if ($urandom_range(9) < 8)
            a = (a & 64'h0000_0000_0000_0FFF) | (64'($urandom_range(15)) << 12)
                | (64'($urandom_range(3)) << 62);
        return a;
    endfunction

    // Directed: reset geometry, extremes of every register and of the address.
    task automatic test_directed();
        send_access(1'b0, 64'd0);
        send_access(1'b1, 64'd0);
        send_access(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(1'b0, 64'd0);
        // Out-of-range index bits and ways, with a wide split that zeroes the tag.
        set_geometry(15, 63, 15);
        send_access(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(1'b0, 64'h8000_0000_0000_0000);
        send_access(1'b0, 64'h0);
        // Ways of zero acts as one; fill and evict a 2-way set.
        set_geometry(0, 4, 0);
        send_access(1'b1, 64'h10);
        send_access(1'b0, 64'h20);
        set_geometry(2, 4, 2);
        for (int i = 0; i < 6; i++)
            send_access(i[0], 64'(i) << 6);
        send_access(1'b0, 64'h0);
        // Shrink the ways midway: stored lines beyond the limit stay untouched.
        set_geometry(2, 4, 8);
        for (int i = 0; i < 9; i++)
            send_access(1'b1, 64'(i) << 6);
        set_geometry(2, 4, 3);
        send_access(1'b0, 64'h200);
        send_access(1'b0, 64'h100);
    endtask

    task automatic test_random(int ib, int ob, int nw, int count);
        set_geometry(ib, ob, nw);
        for (int i = 0; i < count; i++)
            send_access(1'($urandom_range(1)), pick_address());
    endtask

    // Result checker: each accepted beat is compared with the oldest prediction.
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $error("result beat with no access outstanding");
                failures++;
            end
            else
            begin
                e = expected_outcomes.pop_front();
                if (hit !== e.hit)
                begin
                    $error("hit: expected %0d, got %0d", e.hit, hit);
                    failures++;
                end
                if (evicted !== e.evicted)
                begin
                    $error("evicted: expected %0d, got %0d", e.evicted, evicted);
                    failures++;
                end
                if (evicted_dirty !== e.evicted_dirty)
                begin
                    $error("evicted_dirty: expected %0d, got %0d", e.evicted_dirty,
                           evicted_dirty);
                    failures++;
                end
                if (hit_count !== e.hit_count)
                begin
                    $error("hit_count: expected %0d, got %0d", e.hit_count, hit_count);
                    failures++;
                end
                if (miss_count !== e.miss_count)
                begin
                    $error("miss_count: expected %0d, got %0d", e.miss_count, miss_count);
                    failures++;
                end
                if (eviction_count !== e.eviction_count)
                begin
                    $error("eviction_count: expected %0d, got %0d", e.eviction_count,
                           eviction_count);
                    failures++;
                end
                if (dirty_count !== e.dirty_count)
                begin
                    $error("dirty_count: expected %0d, got %0d", e.dirty_count,
                           dirty_count);
                    failures++;
                end
                if (dirty_eviction_count !== e.dirty_eviction_count)
                begin
                    $error("dirty_eviction_count: expected %0d, got %0d",
                           e.dirty_eviction_count, dirty_eviction_count);
                    failures++;
                end
            end
        end
    end

    // Receiver: out_ready is redrawn once per edge, stalling at the phase's rate.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = 1'b0;
        address = '0;
        out_ready = 1'b0;
        failures = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        reg_index_bits = 4'd0;
        reg_offset_bits = 6'd0;
        reg_ways = 4'd1;
        {n_hits, n_misses, n_evictions, n_dirty, n_dirty_evictions} = '0;
        for (int i = 0; i < NUM_SETS * WAYS; i++)
        begin
            mir_tag[i] = '0;
            mir_valid[i] = 1'b0;
            mir_dirty[i] = 1'b0;
            mir_age[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        // Random phases cycle through the idling mixes and several geometries.
        send_idle_pct = 0;  recv_stall_pct = 0;
        test_random(0, 0, 1, 60);
        test_random(2, 4, 4, 80);
        send_idle_pct = 80; recv_stall_pct = 0;
        test_random(3, 5, 8, 100);
        send_idle_pct = 0;  recv_stall_pct = 80;
        test_random(10, 2, 8, 100);
        send_idle_pct = 28; recv_stall_pct = 28;
        test_random(1, 12, 2, 100);
        send_idle_pct = 0;  recv_stall_pct = 0;
        test_random(4, 58, 5, 60);

        wait_idle();
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("lru_set_assoc_cache_sim_top_tb passed");
        else
            $display("lru_set_assoc_cache_sim_top_tb failed");
        $finish;
    end

    // Watchdog: generous bound covering the clearing pass and the stalled phases.
    initial
    begin
        #2000000;
        $display("lru_set_assoc_cache_sim_top_tb failed");
        $finish;
    end
endmodule

// ===== lru_set_assoc_cache_sim_top.f =====
design/lsac_pkg.sv
design/lsac_ctrl.sv
design/lsac_dpath.sv
design/lru_set_assoc_cache_sim_top.sv
tb/lru_set_assoc_cache_sim_top_tb.sv
